FILE: design/sktis_pkg.sv
// Shared constants and types for the sorted key table search block.
`default_nettype none
package sktis_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS = 14;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
	localparam int NUM_BITS = KEY_BITS + IDX_BITS;
	localparam int DIV_STEPS = NUM_BITS;
	localparam int DCNT_BITS = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	typedef struct packed {
		logic                wr_en;
		logic [IDX_BITS-1:0] wr_addr;
		logic [KEY_BITS-1:0] wr_data;
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
	} mem_req_t;
endpackage
`default_nettype wire

FILE: design/sktis_mem.sv
// Key storage: one write port, one registered read port.
`default_nettype none
module sktis_mem
	import sktis_pkg::*;
(
	input  wire logic                clk,
	input  wire mem_req_t            req,
	output logic      [KEY_BITS-1:0] rd_data
);
	logic [KEY_BITS-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: design/sktis_div.sv
// Restoring divider: ceiling quotient, one bit per cycle.
`default_nettype none
module sktis_div
	import sktis_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] num,
	input  wire logic [KEY_BITS-1:0] den,
	output logic                     done,
	output logic      [NUM_BITS-1:0] quot_ceil
);
	logic [NUM_BITS-1:0]  quo_q;
	logic [NUM_BITS-1:0]  num_q;
	logic [KEY_BITS:0]    rem_q;
	logic [KEY_BITS-1:0]  den_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic [KEY_BITS:0]    trial;
	logic [KEY_BITS:0]    shifted;

	assign shifted = {rem_q[KEY_BITS-1:0], num_q[NUM_BITS-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DCNT_BITS'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			if (!trial[KEY_BITS]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot_ceil = quo_q + NUM_BITS'(rem_q != '0);
endmodule
`default_nettype wire

FILE: design/sorted_key_table_interp_search.sv
// Top level: sorted key table with insertion and interpolation search.
//
//   channel | signals                              | dir
//   in      | in_valid in_stall cmd key            | in
//   out     | out_valid out_stall found position entries status | out
//
// Clear goes straight to the output register. An insert moves each larger entry
// through the memory (read, then write back one slot higher), then places the key,
// at slot 0 when every entry moves.
// Each search probe reads and checks the window ends, then, unless they decide the
// result, runs the divider and compares the probed entry.
// Reset empties the table at once; no clearing pass.
// in_stall is high from transfer until the result leaves the output register.
`default_nettype none
module sorted_key_table_interp_search
	import sktis_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     found,
	output logic      [IDX_BITS-1:0] position,
	output logic      [CNT_BITS-1:0] entries,
	output logic                     status
);
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_IRD   = 11'b00000000010,
		ST_ICMP  = 11'b00000000100,
		ST_SRLO  = 11'b00000001000,
		ST_SRHI  = 11'b00000010000,
		ST_SCHK  = 11'b00000100000,
		ST_SDIV  = 11'b00001000000,
		ST_SPRB  = 11'b00010000000,
		ST_SCMP  = 11'b00100000000,
		ST_OUT   = 11'b01000000000,
		ST_IPUT  = 11'b10000000000
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] count_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_BITS-1:0] j_q;
	logic [IDX_BITS-1:0] lo_q;
	logic [IDX_BITS-1:0] hi_q;
	logic [IDX_BITS-1:0] probe_q;
	logic [KEY_BITS-1:0] klo_q;
	logic [KEY_BITS-1:0] khi_q;
	mem_req_t            req;
	logic [KEY_BITS-1:0] rd_data;
	logic                div_start;
	logic                div_done;
	logic [NUM_BITS-1:0] div_num;
	logic [NUM_BITS-1:0] quot;
	logic [NUM_BITS:0]   probe_sum;
	logic [IDX_BITS-1:0] probe_c;

	sktis_mem u_mem (.clk(clk), .req(req), .rd_data(rd_data));

	assign div_num = NUM_BITS'(key_q - klo_q) * NUM_BITS'(hi_q - lo_q);
	sktis_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(khi_q - klo_q), .done(div_done), .quot_ceil(quot)
	);

	assign probe_sum = (NUM_BITS+1)'(lo_q) + (NUM_BITS+1)'(quot);
	assign probe_c = (probe_sum > (NUM_BITS+1)'(hi_q)) ? hi_q
		: probe_sum[IDX_BITS-1:0];

	assign in_stall = (state_q != ST_IDLE);
	assign div_start = (state_q == ST_SPRB) && !(key_q < klo_q || key_q > khi_q)
		&& (klo_q != khi_q);

	always_comb begin
		req = '0;
		case (state_q)
			ST_IRD: begin
				req.rd_en = 1'b1;
				req.rd_addr = j_q - 1'b1;
			end
			ST_ICMP: begin
				req.wr_en = 1'b1;
				req.wr_addr = j_q;
				req.wr_data = (rd_data > key_q) ? rd_data : key_q;
			end
			ST_IPUT: begin
				req.wr_en = 1'b1;
				req.wr_addr = j_q;
				req.wr_data = key_q;
			end
			ST_SRLO: begin
				req.rd_en = 1'b1;
				req.rd_addr = lo_q;
			end
			ST_SRHI: begin
				req.rd_en = 1'b1;
				req.rd_addr = hi_q;
			end
			ST_SDIV: begin
				req.rd_en = div_done;
				req.rd_addr = probe_c;
			end
			ST_IDLE: begin
				req.wr_en = in_valid && cmd == CMD_INSERT
					&& count_q == '0;
				req.wr_addr = '0;
				req.wr_data = key;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q <= key;
						found <= 1'b0;
						position <= '0;
						lo_q <= '0;
						hi_q <= IDX_BITS'(count_q - 1'b1);
						j_q <= count_q[IDX_BITS-1:0];
						case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								entries <= '0;
								status <= 1'b0;
								out_valid <= 1'b1;
								state_q <= ST_OUT;
							end
							CMD_INSERT: begin
								if (count_q == CNT_BITS'(TABLE_DEPTH)) begin
									entries <= count_q;
									status <= 1'b1;
									out_valid <= 1'b1;
									state_q <= ST_OUT;
								end else if (count_q == '0) begin
									count_q <= CNT_BITS'(1);
									entries <= CNT_BITS'(1);
									status <= 1'b0;
									out_valid <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									entries <= count_q;
									status <= 1'b0;
									state_q <= ST_IRD;
								end
							end
							CMD_SEARCH: begin
								entries <= count_q;
								status <= 1'b0;
								if (count_q != '0) begin
									state_q <= ST_SRLO;
								end else begin
									out_valid <= 1'b1;
									state_q <= ST_OUT;
								end
							end
							default: begin
								entries <= count_q;
								status <= 1'b0;
								out_valid <= 1'b1;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_IRD: state_q <= ST_ICMP;
				ST_ICMP: begin
					if (rd_data > key_q) begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == IDX_BITS'(1)) ? ST_IPUT : ST_IRD;
					end else begin
						position <= j_q;
						count_q <= count_q + 1'b1;
						entries <= count_q + 1'b1;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_IPUT: begin
					position <= j_q;
					count_q <= count_q + 1'b1;
					entries <= count_q + 1'b1;
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_SRLO: state_q <= ST_SRHI;
				ST_SRHI: begin
					klo_q <= rd_data;
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					khi_q <= rd_data;
					state_q <= ST_SPRB;
				end
				ST_SPRB: begin
					if (key_q < klo_q || key_q > khi_q) begin
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (klo_q == khi_q) begin
						found <= (key_q == klo_q);
						position <= (key_q == klo_q) ? lo_q : '0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						probe_q <= probe_c;
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					if (key_q == rd_data) begin
						found <= 1'b1;
						position <= probe_q;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (key_q < rd_data) begin
						if (probe_q == lo_q) begin
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							hi_q <= probe_q - 1'b1;
							state_q <= ST_SRLO;
						end
					end else begin
						if (probe_q == hi_q) begin
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							lo_q <= probe_q + 1'b1;
							state_q <= ST_SRLO;
						end
					end
				end
				ST_OUT: begin
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
